@@ hw/rtl/sfs_pkg.sv @@
// sfs_pkg: shared types, codes and the control store of the sprite frame sequencer
// no dependencies; used by sfs_div, sfs_seq and sprite_frame_sequencer

package sfs_pkg;

  // input op codes
  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpPlay  = 2'd1;
  localparam logic [1:0] OpReset = 2'd2;

  // register indexes
  localparam logic [2:0] RegSheetMode  = 3'd0;
  localparam logic [2:0] RegFrameCount = 3'd1;
  localparam logic [2:0] RegColumns    = 3'd2;
  localparam logic [2:0] RegRows       = 3'd3;
  localparam logic [2:0] RegDuration   = 3'd4;
  localparam logic [2:0] RegLoop       = 3'd5;
  localparam logic [2:0] RegWidth      = 3'd6;
  localparam logic [2:0] RegHeight     = 3'd7;

  // sheet modes, also the offset into the dispatch table
  localparam logic [1:0] ModeSingle   = 2'd0;
  localparam logic [1:0] ModeMulti    = 2'd1;
  localparam logic [1:0] ModeSeparate = 2'd2;

  localparam int NumW   = 24;
  localparam int DenW   = 16;
  localparam int PairsW = 4;
  localparam int StepW  = 5;

  typedef logic [StepW-1:0] step_t;

  localparam step_t StepIdle     = 5'd0;
  localparam step_t StepDispatch = 5'd6;
  localparam step_t StepSingle   = 5'd9;
  localparam step_t StepMulti    = 5'd13;
  localparam step_t StepOut      = 5'd22;

  typedef enum logic [2:0] {
    C_NEXT, C_GOTO, C_WAIT_IN, C_WAIT_DIV, C_WAIT_OUT, C_MODE
  } cond_t;

  typedef enum logic [3:0] {
    A_NONE, A_ACCEPT, A_UPDATE, A_FRAME, A_FW, A_FH, A_ROWCOL, A_SX, A_SY, A_OUT
  } act_t;

  typedef enum logic [2:0] {
    M_NONE, M_TIME, M_SINGLE, M_COL, M_ROW
  } mul_t;

  typedef enum logic [2:0] {
    D_NONE, D_TIME, D_WF, D_WC, D_HR, D_FC
  } dsel_t;

  typedef struct packed {
    act_t  act;
    mul_t  mul_op;
    dsel_t div_op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic       in_valid;
    logic       div_busy;
    logic       out_stall;
    logic [1:0] mode_sel;
  } seq_stat_t;

  typedef struct packed {
    logic  fire;
    act_t  act;
    mul_t  mul_op;
    dsel_t div_op;
  } seq_ctrl_t;

  typedef struct packed {
    logic              go;
    logic [PairsW-1:0] pairs;
  } div_req_t;

  // control store
  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    w = '{act: A_NONE, mul_op: M_NONE, div_op: D_NONE, cond: C_NEXT, target: StepIdle};
    case (pc)
      5'd0: begin
        w.act  = A_ACCEPT;
        w.cond = C_WAIT_IN;
      end
      5'd1: w.act = A_UPDATE;
      5'd2: w.mul_op = M_TIME;
      5'd3: w.div_op = D_TIME;
      5'd4: begin
        w.act  = A_FRAME;
        w.cond = C_WAIT_DIV;
      end
      5'd5: begin
        w.cond   = C_MODE;
        w.target = StepDispatch;
      end
      5'd6: begin
        w.cond   = C_GOTO;
        w.target = StepSingle;
      end
      5'd7: begin
        w.cond   = C_GOTO;
        w.target = StepMulti;
      end
      5'd8: begin
        w.cond   = C_GOTO;
        w.target = StepOut;
      end
      // single-row sheet
      5'd9: w.div_op = D_WF;
      5'd10: begin
        w.act  = A_FW;
        w.cond = C_WAIT_DIV;
      end
      5'd11: w.mul_op = M_SINGLE;
      5'd12: begin
        w.act    = A_SX;
        w.cond   = C_GOTO;
        w.target = StepOut;
      end
      // multi-row sheet
      5'd13: w.div_op = D_WC;
      5'd14: begin
        w.act  = A_FW;
        w.cond = C_WAIT_DIV;
      end
      5'd15: w.div_op = D_HR;
      5'd16: begin
        w.act  = A_FH;
        w.cond = C_WAIT_DIV;
      end
      5'd17: w.div_op = D_FC;
      5'd18: begin
        w.act  = A_ROWCOL;
        w.cond = C_WAIT_DIV;
      end
      5'd19: w.mul_op = M_COL;
      5'd20: begin
        w.mul_op = M_ROW;
        w.act    = A_SX;
      end
      5'd21: w.act = A_SY;
      5'd22: begin
        w.act    = A_OUT;
        w.cond   = C_WAIT_OUT;
        w.target = StepIdle;
      end
      default: begin
        w.cond   = C_GOTO;
        w.target = StepIdle;
      end
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/sfs_div.sv @@
// sfs_div: restoring divider, two quotient bits per cycle, left-aligned numerator
// depends on sfs_pkg

module sfs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sfs_pkg::div_req_t           req,
  input  logic [sfs_pkg::NumW-1:0]    num,
  input  logic [sfs_pkg::DenW-1:0]    den,
  output logic                        busy,
  output logic [sfs_pkg::NumW-1:0]    quo,
  output logic [sfs_pkg::DenW-1:0]    rem
);

  logic                          busy_r;
  logic [sfs_pkg::PairsW-1:0]    cnt_r;
  logic [sfs_pkg::NumW-1:0]      n_r;
  logic [sfs_pkg::NumW-1:0]      q_r;
  logic [sfs_pkg::DenW-1:0]      r_r;
  logic [sfs_pkg::DenW-1:0]      d_r;

  logic [sfs_pkg::DenW:0]        t1, t2;
  logic                          ge1, ge2;
  logic [sfs_pkg::DenW-1:0]      r1, r2;

  always_comb begin
    t1  = {r_r, n_r[sfs_pkg::NumW-1]};
    ge1 = t1 >= {1'b0, d_r};
    r1  = ge1 ? sfs_pkg::DenW'(t1 - {1'b0, d_r}) : t1[sfs_pkg::DenW-1:0];
    t2  = {r1, n_r[sfs_pkg::NumW-2]};
    ge2 = t2 >= {1'b0, d_r};
    r2  = ge2 ? sfs_pkg::DenW'(t2 - {1'b0, d_r}) : t2[sfs_pkg::DenW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.go) begin
      busy_r <= req.pairs != '0;
      cnt_r  <= req.pairs;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - sfs_pkg::PairsW'(1);
      busy_r <= cnt_r != sfs_pkg::PairsW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      n_r <= num;
      d_r <= den;
      r_r <= '0;
      q_r <= '0;
    end else if (busy_r) begin
      n_r <= {n_r[sfs_pkg::NumW-3:0], 2'b00};
      r_r <= r2;
      q_r <= {q_r[sfs_pkg::NumW-3:0], ge1, ge2};
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule

@@ hw/rtl/sfs_seq.sv @@
// sfs_seq: step counter, control store lookup and jump logic
// depends on sfs_pkg

module sfs_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  sfs_pkg::seq_stat_t  stat,
  output sfs_pkg::seq_ctrl_t  ctrl
);

  sfs_pkg::step_t  pc_r, pc_nxt;
  sfs_pkg::uword_t uw;
  logic            stall;

  assign uw = sfs_pkg::ucode(pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= sfs_pkg::StepIdle;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    stall  = 1'b0;
    pc_nxt = pc_r + sfs_pkg::step_t'(1);
    case (uw.cond)
      sfs_pkg::C_NEXT: pc_nxt = pc_r + sfs_pkg::step_t'(1);
      sfs_pkg::C_GOTO: pc_nxt = uw.target;
      sfs_pkg::C_WAIT_IN: begin
        stall  = !stat.in_valid;
        pc_nxt = stall ? pc_r : pc_r + sfs_pkg::step_t'(1);
      end
      sfs_pkg::C_WAIT_DIV: begin
        stall  = stat.div_busy;
        pc_nxt = stall ? pc_r : pc_r + sfs_pkg::step_t'(1);
      end
      sfs_pkg::C_WAIT_OUT: begin
        stall  = stat.out_stall;
        pc_nxt = stall ? pc_r : uw.target;
      end
      sfs_pkg::C_MODE: pc_nxt = uw.target + sfs_pkg::step_t'(stat.mode_sel);
      default: pc_nxt = sfs_pkg::StepIdle;
    endcase
    ctrl.fire   = !stall;
    ctrl.act    = uw.act;
    ctrl.mul_op = uw.mul_op;
    ctrl.div_op = uw.div_op;
  end

endmodule

@@ hw/rtl/sprite_frame_sequencer.sv @@
// sprite_frame_sequencer: register file, datapath and channel logic of the block
// depends on sfs_pkg, sfs_seq and sfs_div
//
// Each item (tick, play or reset) updates the animation time, the ended flag or
// both, and returns the current frame as an image index and a source rectangle.
// One item is in work at a time; the next item can be taken in the cycle after
// the last result is registered. Items wait on the shared divider, which yields
// two quotient bits a cycle, for the frame number, a frame size and the row and
// column. A finished result sits in the output register while the next item is
// taken. Configuration writes are accepted at any time but belong in idle periods.

module sprite_frame_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // delta
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  // image_index[7:0], src_x[19:8], src_y[31:20], rect_width[44:32],
  // rect_height[57:45], ended[58], zero[63:59]
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic [1:0]  mode_r;
  logic [8:0]  fcount_r, cols_cfg_r, rows_cfg_r;
  logic [15:0] dur_cfg_r;
  logic        loop_r;
  logic [12:0] w_cfg_r, h_cfg_r;

  // state and working registers
  logic [15:0] elapsed_r;
  logic        ended_r;
  logic [1:0]  op_r;
  logic [15:0] delta_r;
  logic [24:0] prod_r;
  logic [7:0]  frame_r, row_r, col_r;
  logic [12:0] fw_r, fh_r;
  logic [11:0] sx_r, sy_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;

  logic [8:0]  frames, cols, rows, fmax;
  logic [15:0] dur;
  logic [12:0] w, h;
  logic [1:0]  mode_sel;

  logic [15:0] t0, d0, tick_time;
  logic [16:0] tsum;
  logic        wrap;

  logic [15:0] mul_a;
  logic [8:0]  mul_b;
  logic [11:0] prod_sat;

  sfs_pkg::div_req_t           dreq;
  logic [sfs_pkg::NumW-1:0]    dnum, dquo;
  logic [sfs_pkg::DenW-1:0]    dden, drem;
  logic                        dbusy;

  sfs_pkg::seq_stat_t stat;
  sfs_pkg::seq_ctrl_t ctrl;

  logic [7:0]  o_idx;
  logic [11:0] o_sx, o_sy;
  logic [12:0] o_rw, o_rh;

  // register limits
  always_comb begin
    frames = (fcount_r == '0) ? 9'd1 : ((fcount_r > 9'd256) ? 9'd256 : fcount_r);
    cols   = (cols_cfg_r == '0) ? 9'd1 : ((cols_cfg_r > 9'd256) ? 9'd256 : cols_cfg_r);
    rows   = (rows_cfg_r == '0) ? 9'd1 : ((rows_cfg_r > 9'd256) ? 9'd256 : rows_cfg_r);
    dur    = (dur_cfg_r == '0) ? 16'd1 : dur_cfg_r;
    w      = (w_cfg_r == '0) ? 13'd1 : ((w_cfg_r > 13'd4096) ? 13'd4096 : w_cfg_r);
    h      = (h_cfg_r == '0) ? 13'd1 : ((h_cfg_r > 13'd4096) ? 13'd4096 : h_cfg_r);
    fmax   = frames - 9'd1;
    mode_sel = (mode_r == sfs_pkg::ModeMulti || mode_r == sfs_pkg::ModeSeparate) ?
               mode_r : sfs_pkg::ModeSingle;
  end

  // tick time update
  always_comb begin
    t0   = (elapsed_r > dur) ? dur : elapsed_r;
    d0   = (delta_r > dur) ? dur : delta_r;
    tsum = {1'b0, t0} + {1'b0, d0};
    wrap = tsum >= {1'b0, dur};
    if (!wrap) begin
      tick_time = tsum[15:0];
    end else if (loop_r) begin
      tick_time = 16'(tsum - {1'b0, dur});
    end else begin
      tick_time = dur;
    end
  end

  // multiplier operands
  always_comb begin
    mul_a = elapsed_r;
    mul_b = frames;
    case (ctrl.mul_op)
      sfs_pkg::M_TIME: begin
        mul_a = elapsed_r;
        mul_b = frames;
      end
      sfs_pkg::M_SINGLE: begin
        mul_a = {3'b0, fw_r};
        mul_b = {1'b0, frame_r};
      end
      sfs_pkg::M_COL: begin
        mul_a = {3'b0, fw_r};
        mul_b = {1'b0, col_r};
      end
      sfs_pkg::M_ROW: begin
        mul_a = {3'b0, fh_r};
        mul_b = {1'b0, row_r};
      end
      default: begin
        mul_a = elapsed_r;
        mul_b = frames;
      end
    endcase
  end

  assign prod_sat = (prod_r > 25'd4095) ? 12'hFFF : prod_r[11:0];

  // divider operands
  always_comb begin
    dnum       = '0;
    dden       = dur;
    dreq.pairs = '0;
    case (ctrl.div_op)
      sfs_pkg::D_TIME: begin
        dnum       = prod_r[sfs_pkg::NumW-1:0];
        dden       = dur;
        dreq.pairs = 4'd12;
      end
      sfs_pkg::D_WF: begin
        dnum       = {1'b0, w, 10'b0};
        dden       = {7'b0, frames};
        dreq.pairs = 4'd7;
      end
      sfs_pkg::D_WC: begin
        dnum       = {1'b0, w, 10'b0};
        dden       = {7'b0, cols};
        dreq.pairs = 4'd7;
      end
      sfs_pkg::D_HR: begin
        dnum       = {1'b0, h, 10'b0};
        dden       = {7'b0, rows};
        dreq.pairs = 4'd7;
      end
      sfs_pkg::D_FC: begin
        dnum       = {frame_r, 16'b0};
        dden       = {7'b0, cols};
        dreq.pairs = 4'd4;
      end
      default: begin
        dnum       = '0;
        dden       = dur;
        dreq.pairs = '0;
      end
    endcase
    dreq.go = ctrl.fire && (ctrl.div_op != sfs_pkg::D_NONE);
  end

  sfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .num   (dnum),
    .den   (dden),
    .busy  (dbusy),
    .quo   (dquo),
    .rem   (drem)
  );

  assign stat.in_valid  = in_tvalid;
  assign stat.div_busy  = dbusy;
  assign stat.out_stall = out_valid_r && !out_tready;
  assign stat.mode_sel  = mode_sel;

  sfs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // result fields
  always_comb begin
    o_idx = (mode_sel == sfs_pkg::ModeSeparate) ? frame_r : 8'd0;
    o_sx  = (mode_sel == sfs_pkg::ModeSeparate) ? 12'd0 : sx_r;
    o_sy  = (mode_sel == sfs_pkg::ModeMulti) ? sy_r : 12'd0;
    o_rw  = (mode_sel == sfs_pkg::ModeSeparate) ? w : fw_r;
    o_rh  = (mode_sel == sfs_pkg::ModeMulti) ? fh_r : h;
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= sfs_pkg::ModeSingle;
      fcount_r    <= 9'd1;
      cols_cfg_r  <= 9'd1;
      rows_cfg_r  <= 9'd1;
      dur_cfg_r   <= 16'd1;
      loop_r      <= 1'b0;
      w_cfg_r     <= 13'd1;
      h_cfg_r     <= 13'd1;
      elapsed_r   <= '0;
      ended_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          sfs_pkg::RegSheetMode:  mode_r     <= cfg_data[1:0];
          sfs_pkg::RegFrameCount: fcount_r   <= cfg_data[8:0];
          sfs_pkg::RegColumns:    cols_cfg_r <= cfg_data[8:0];
          sfs_pkg::RegRows:       rows_cfg_r <= cfg_data[8:0];
          sfs_pkg::RegDuration:   dur_cfg_r  <= cfg_data;
          sfs_pkg::RegLoop:       loop_r     <= cfg_data[0];
          sfs_pkg::RegWidth:      w_cfg_r    <= cfg_data[12:0];
          sfs_pkg::RegHeight:     h_cfg_r    <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (ctrl.fire && ctrl.act == sfs_pkg::A_UPDATE) begin
        case (op_r)
          sfs_pkg::OpTick: begin
            elapsed_r <= tick_time;
            if (wrap && !loop_r) begin
              ended_r <= 1'b1;
            end
          end
          sfs_pkg::OpPlay: ended_r <= 1'b0;
          sfs_pkg::OpReset: begin
            elapsed_r <= '0;
            ended_r   <= 1'b1;
          end
          default: ;
        endcase
      end
      if (ctrl.fire && ctrl.act == sfs_pkg::A_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.mul_op != sfs_pkg::M_NONE) begin
      prod_r <= {9'b0, mul_a} * {16'b0, mul_b};
    end
    if (ctrl.fire) begin
      case (ctrl.act)
        sfs_pkg::A_ACCEPT: begin
          op_r    <= in_tuser;
          delta_r <= in_tdata;
        end
        sfs_pkg::A_FRAME: begin
          frame_r <= (dquo > {15'b0, fmax}) ? fmax[7:0] : dquo[7:0];
        end
        sfs_pkg::A_FW: fw_r <= dquo[12:0];
        sfs_pkg::A_FH: fh_r <= dquo[12:0];
        sfs_pkg::A_ROWCOL: begin
          row_r <= dquo[7:0];
          col_r <= drem[7:0];
        end
        sfs_pkg::A_SX: sx_r <= prod_sat;
        sfs_pkg::A_SY: sy_r <= prod_sat;
        sfs_pkg::A_OUT: begin
          out_data_r <= {5'b0, ended_r, o_rh, o_rw, o_sy, o_sx, o_idx};
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = ctrl.act == sfs_pkg::A_ACCEPT;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

endmodule

@@ hw/rtl/sfs_chk.sv @@
// sfs_chk: port-level checks of the sprite frame sequencer and their bind
// depends on the ports of sprite_frame_sequencer

module sfs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item in work: no new item right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // a result never appears right after its item is taken
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result too early");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:59] == 5'd0)
    else $error("nonzero padding in result");

endmodule

bind sprite_frame_sequencer sfs_chk u_sfs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
